@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the point angle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pad_pkg.sv @@
// Types, constants and threshold tables of the point angle block.
package pad_pkg;

    // Coordinate and derived widths
    localparam int COORD_BITS   = 12;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int MAG_W        = COORD_BITS;
    localparam int BASE_STEPS   = 89;
    localparam int K_W          = $clog2(BASE_STEPS + 1);
    localparam int ANGLE_W      = 10;
    localparam int TAB_W        = 46;
    localparam int PROD_W       = MAG_W + TAB_W;
    localparam int IN_W         = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((ANGLE_W + 7) / 8) * 8;

    // Table generation: Q60 Taylor series, rounded to Q46
    localparam int          SERIES_TERMS = 24;
    localparam int          TABLE_DROP   = 60 - TAB_W;
    localparam logic [63:0] Q60_ONE      = 64'd1 << 60;
    localparam logic [63:0] ANGLE_DIV    = 64'd57;
    localparam logic [63:0] ROUND_HALF   = 64'd1 << (TABLE_DROP - 1);
    localparam logic [63:0] X_STEP       = Q60_ONE / ANGLE_DIV;
    localparam logic [63:0] X_REM        = Q60_ONE % ANGLE_DIV;

    // Result codes
    localparam logic [ANGLE_W-1:0] ANG_NONE  = '1;
    localparam logic [ANGLE_W-1:0] ANG_RIGHT = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] ANG_UP    = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] ANG_LEFT  = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] ANG_DOWN  = ANGLE_W'(270);
    localparam logic [ANGLE_W-1:0] ANG_FULL  = ANGLE_W'(360);

    // Quadrant of the direction (screen y down)
    typedef enum logic [1:0] {
        QUAD_UR = 2'd0,
        QUAD_UL = 2'd1,
        QUAD_DR = 2'd2,
        QUAD_DL = 2'd3
    } t_quad;

    // One point pair as packed in the input word, last field lowest
    typedef struct packed {
        logic signed [COORD_BITS-1:0] to_y;
        logic signed [COORD_BITS-1:0] to_x;
        logic signed [COORD_BITS-1:0] from_y;
        logic signed [COORD_BITS-1:0] from_x;
    } t_pts;

    // Item traveling down the chain
    typedef struct packed {
        logic               valid;
        logic               has_prod;
        logic               special;
        logic [ANGLE_W-1:0] spec_angle;
        t_quad              quad;
        logic [MAG_W-1:0]   a;
        logic [MAG_W-1:0]   b;
        logic [K_W-1:0]     k;
    } t_lane;

    // Products of one threshold, compared by the next cell
    typedef struct packed {
        logic [PROD_W-1:0] pc;
        logic [PROD_W-1:0] ps;
    } t_prod;

    // Finished result
    typedef struct packed {
        logic               valid;
        logic [ANGLE_W-1:0] angle;
    } t_res;

    typedef logic [TAB_W-1:0] t_tab [0:BASE_STEPS];

    // Truncated Q60 product, built from 32-bit halves
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl;
        ah = a >> 32;
        al = {32'd0, a[31:0]};
        bh = b >> 32;
        bl = {32'd0, b[31:0]};
        return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    // Truncating unsigned quotient by shift and subtract, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, r;
        int          i;
        q = '0;
        r = '0;
        for (i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin or cos of j/57 in Q46 for j = 0..BASE_STEPS, elaboration only
    function automatic t_tab build_tab(input logic want_cos);
        t_tab        tab;
        logic [63:0] x, x2, term, s, c, acc;
        int          j, n;
        for (j = 0; j <= BASE_STEPS; j++) begin
            x  = X_STEP * 64'(j) + div_u64(X_REM * 64'(j), ANGLE_DIV);
            x2 = mul_q60(x, x);
            term = x;
            s    = x;
            for (n = 1; n <= SERIES_TERMS; n++) begin
                term = div_u64(mul_q60(term, x2), 64'(2 * n) * 64'(2 * n + 1));
                s    = (n % 2 == 1) ? s - term : s + term;
            end
            term = Q60_ONE;
            c    = Q60_ONE;
            for (n = 1; n <= SERIES_TERMS; n++) begin
                term = div_u64(mul_q60(term, x2), 64'(2 * n - 1) * 64'(2 * n));
                c    = (n % 2 == 1) ? c - term : c + term;
            end
            acc    = want_cos ? c : s;
            tab[j] = TAB_W'((acc + ROUND_HALF) >> TABLE_DROP);
        end
        return tab;
    endfunction

    localparam t_tab SIN_TAB = build_tab(1'b0);
    localparam t_tab COS_TAB = build_tab(1'b1);

endpackage

@@ rtl/core/point_angle_degrees.sv @@
// Top level: point pair in, direction in degrees out.
// Takes one point pair per cycle; its direction passes through one front
// stage that forms the differences, a row of 89 cells each checking one
// tan(j/57) threshold with two constant products, one back stage that
// maps the count to degrees, and an output register with a one-word skid
// stage that decouples the master side.
// Throughput is one word per cycle; the input stalls only while the skid
// stage is full. Angles: 0 right, 90 up (screen y down), all ones for equal points.
`include "assert_macros.svh"

module point_angle_degrees (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // from_x, from_y, to_x, to_y (low to high)
    input  logic [pad_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // angle, zero padded
    output logic [pad_pkg::OUT_W-1:0] o_m_tdata
);
    import pad_pkg::*;

    logic               w_en;
    t_pts               w_pts;
    t_lane              w_lane [0:BASE_STEPS];
    t_prod              w_prod [0:BASE_STEPS];
    t_res               w_res;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    logic [ANGLE_W-1:0] r_out, n_out;
    logic [ANGLE_W-1:0] r_skid, n_skid;

    // Whole chain advances while the skid stage is free
    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;
    assign w_pts      = t_pts'(i_s_tdata[4*COORD_BITS-1:0]);

    pad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_pts   (w_pts),
        .o_lane  (w_lane[0])
    );

    // No threshold weighed ahead of the first cell
    assign w_prod[0] = '0;

    // Threshold cells
    for (genvar g = 1; g <= BASE_STEPS; g++) begin : g_cell
        pad_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_sin   (SIN_TAB[g]),
            .i_cos   (COS_TAB[g]),
            .i_lane  (w_lane[g-1]),
            .i_prod  (w_prod[g-1]),
            .o_lane  (w_lane[g]),
            .o_prod  (w_prod[g])
        );
    end

    pad_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_lane  (w_lane[BASE_STEPS]),
        .i_prod  (w_prod[BASE_STEPS]),
        .o_res   (w_res)
    );

    // Output register and skid stage
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (i_m_tready) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else begin
            if (i_m_tready) begin
                n_out_valid = 1'b0;
            end
            if (w_res.valid) begin
                if (!r_out_valid || i_m_tready) begin
                    n_out       = w_res.angle;
                    n_out_valid = 1'b1;
                end else begin
                    n_skid       = w_res.angle;
                    n_skid_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out);

    `ASSERT_IMPLY(a_skid_behind_out, r_skid_valid, r_out_valid, "skid word without output word")
    `ASSERT_NEXT(a_skid_holds, r_skid_valid && !i_m_tready, r_skid_valid && r_out_valid, "skid word lost while stalled")

endmodule

@@ rtl/core/pad_cell.sv @@
// One threshold cell: settles the previous compare and forms its own products.
`include "assert_macros.svh"

module pad_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [pad_pkg::TAB_W-1:0] i_sin,
    input  logic [pad_pkg::TAB_W-1:0] i_cos,
    input  pad_pkg::t_lane           i_lane,
    input  pad_pkg::t_prod           i_prod,
    output pad_pkg::t_lane           o_lane,
    output pad_pkg::t_prod           o_prod
);
    import pad_pkg::*;

    t_lane r_lane, n_lane;
    t_prod r_prod, n_prod;

    // Count the previous threshold if passed, then weigh this one
    always_comb begin
        n_lane = i_lane;
        if (i_lane.has_prod && (i_prod.pc >= i_prod.ps)) begin
            n_lane.k = i_lane.k + K_W'(1);
        end
        n_lane.has_prod = 1'b1;
        n_prod.pc = PROD_W'(i_lane.a) * PROD_W'(i_cos);
        n_prod.ps = PROD_W'(i_lane.b) * PROD_W'(i_sin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    // Products need no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_lane = r_lane;
    assign o_prod = r_prod;

    `ASSERT_IMPLY(a_k_bound, r_lane.valid, r_lane.k <= K_W'(BASE_STEPS), "base angle count overflow")

endmodule

@@ rtl/core/pad_front.sv @@
// Front stage: coordinate differences, magnitudes and special-case sorting.
`include "assert_macros.svh"

module pad_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pad_pkg::t_pts  i_pts,
    output pad_pkg::t_lane o_lane
);
    import pad_pkg::*;

    logic signed [DIFF_W-1:0] w_dx, w_dy, w_dx_neg, w_dy_neg;
    logic                     w_dx_zero, w_dy_zero, w_dx_lt, w_dy_lt;
    t_lane                    r_lane, n_lane;

    // Sign-extended differences and their negations
    assign w_dx = $signed({i_pts.to_x[COORD_BITS-1], i_pts.to_x})
                - $signed({i_pts.from_x[COORD_BITS-1], i_pts.from_x});
    assign w_dy = $signed({i_pts.to_y[COORD_BITS-1], i_pts.to_y})
                - $signed({i_pts.from_y[COORD_BITS-1], i_pts.from_y});
    assign w_dx_neg  = -w_dx;
    assign w_dy_neg  = -w_dy;
    assign w_dx_zero = (w_dx == '0);
    assign w_dy_zero = (w_dy == '0);
    assign w_dx_lt   = w_dx[DIFF_W-1];
    assign w_dy_lt   = w_dy[DIFF_W-1];

    // Classify the pair
    always_comb begin
        n_lane          = '0;
        n_lane.valid    = i_valid;
        n_lane.a        = w_dy_lt ? w_dy_neg[MAG_W-1:0] : w_dy[MAG_W-1:0];
        n_lane.b        = w_dx_lt ? w_dx_neg[MAG_W-1:0] : w_dx[MAG_W-1:0];
        n_lane.special  = w_dx_zero || w_dy_zero;
        priority if (w_dx_zero && w_dy_zero) begin
            n_lane.spec_angle = ANG_NONE;
        end else if (w_dx_zero) begin
            n_lane.spec_angle = w_dy_lt ? ANG_UP : ANG_DOWN;
        end else if (w_dy_zero) begin
            n_lane.spec_angle = w_dx_lt ? ANG_LEFT : ANG_RIGHT;
        end else begin
            n_lane.spec_angle = ANG_NONE;
        end
        priority if (!w_dx_lt && w_dy_lt) begin
            n_lane.quad = QUAD_UR;
        end else if (w_dx_lt && w_dy_lt) begin
            n_lane.quad = QUAD_UL;
        end else if (!w_dx_lt) begin
            n_lane.quad = QUAD_DR;
        end else begin
            n_lane.quad = QUAD_DL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

    `ASSERT_IMPLY(a_general_nonzero, r_lane.valid && !r_lane.special, (r_lane.a != '0) && (r_lane.b != '0), "general case with zero leg")

endmodule

@@ rtl/core/pad_back.sv @@
// Back stage: last threshold compare and quadrant mapping to degrees.
`include "assert_macros.svh"

module pad_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  pad_pkg::t_lane i_lane,
    input  pad_pkg::t_prod i_prod,
    output pad_pkg::t_res  o_res
);
    import pad_pkg::*;

    logic [K_W-1:0]     w_k;
    logic [ANGLE_W-1:0] w_kx;
    t_res               r_res, n_res;

    // Final count
    assign w_k  = (i_lane.has_prod && (i_prod.pc >= i_prod.ps)) ? i_lane.k + K_W'(1)
                                                                 : i_lane.k;
    assign w_kx = ANGLE_W'(w_k);

    // Quadrant rule
    always_comb begin
        n_res.valid = i_lane.valid;
        if (i_lane.special) begin
            n_res.angle = i_lane.spec_angle;
        end else begin
            unique case (i_lane.quad)
                QUAD_UR: n_res.angle = w_kx;
                QUAD_UL: n_res.angle = ANG_LEFT - w_kx;
                QUAD_DR: n_res.angle = ANG_FULL - w_kx;
                QUAD_DL: n_res.angle = ANG_LEFT + w_kx;
                default: n_res.angle = ANG_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    `ASSERT_IMPLY(a_angle_range, r_res.valid, (r_res.angle == ANG_NONE) || (r_res.angle <= ANG_FULL), "angle out of range")

endmodule
